// ===== rtl/b58enc_pkg.sv =====
package b58enc_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
		logic       too_long;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FOLD,
		ST_PREP,
		ST_EMIT
	} state_t;

	localparam int RESULT_CAP = 55;
	localparam int EMIT_W     = 6;
	localparam int DIGIT_W    = 6;
	localparam int CARRY_W    = 8;
	localparam int RADIX      = 58;

	// 256 = 4 * 58 + 24, so d*256 + c = 4*d*58 + (24*d + c)
	localparam int LOW_MUL    = 24;
	localparam int LOW_W      = 11;
	// floor(t / 58) = (t * 1130) >> 16, exact for t < 2^14
	localparam int RECIP      = 1130;
	localparam int RECIP_SH   = 16;
	localparam int PROD_W     = 21;
	localparam int QLOW_W     = PROD_W - RECIP_SH;

	localparam logic [6:0] CHAR_ONE = 7'h31;

	localparam logic [58*8-1:0] ALPHABET =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	function automatic logic [6:0] alpha_char(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] dd;
		logic [DIGIT_W-1:0] idx;
		dd  = (d > DIGIT_W'(RADIX - 1)) ? '0 : d;
		idx = DIGIT_W'(RADIX - 1) - dd;
		return ALPHABET[{idx, 3'b000} +: 7];
	endfunction

endpackage

// ===== rtl/base58_encoder_top.sv =====
// Base-58 encoder (bitcoin alphabet). A byte is taken when start is high and busy is low.
// Each byte after the leading zeros is folded into the stored base-58 digits one digit per
// cycle through a single divide-by-58 step, and busy stays high until that fold is done;
// leading zeros and dropped bytes are not folded. After the last byte (and its fold),
// state PREP sizes the output and the first EMIT state issues the first digit read;
// then one character per cycle follows on result with strobe
// high, leading '1's first and then digits from most significant down, the final one with
// last_char set. Results cannot be held off: the receiver must take one every cycle
// that strobe is high. Bytes past MAX_BYTES are dropped and too_long is set on every
// character of that string; at most 55 characters are sent.
module base58_encoder_top #(
	parameter int MAX_BYTES  = 40,
	parameter int MAX_DIGITS = 55
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  b58enc_pkg::in_item_t  item,
	output logic                  strobe,
	output b58enc_pkg::result_t   result
);

	localparam int AW  = $clog2(MAX_DIGITS);
	localparam int CW  = $clog2(MAX_DIGITS + 1);
	localparam int BW  = $clog2(MAX_BYTES + 1);
	localparam int TW0 = $clog2(MAX_BYTES + MAX_DIGITS + 1);
	localparam int TW  = (TW0 > 7) ? TW0 : 7;

	localparam int DW  = b58enc_pkg::DIGIT_W;
	localparam int KW  = b58enc_pkg::CARRY_W;
	localparam int LW  = b58enc_pkg::LOW_W;
	localparam int PW  = b58enc_pkg::PROD_W;
	localparam int QW  = b58enc_pkg::QLOW_W;
	localparam int EW  = b58enc_pkg::EMIT_W;

	b58enc_pkg::state_t state_q, state_d;

	logic [DW-1:0] mem [MAX_DIGITS];
	logic [DW-1:0] rd_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	logic [CW-1:0] dcount_q;
	logic [BW-1:0] zero_q;
	logic [BW-1:0] byte_q;
	logic          seen_q;
	logic          ovf_q;
	logic          last_pend_q;
	logic [CW-1:0] j_q;
	logic [KW-1:0] carry_q;
	logic [EW-1:0] emit_left_q;
	logic [BW-1:0] zeros_left_q;
	logic [AW-1:0] pos_q;

	logic          valid_s1;
	logic          one_s1;
	logic          last_s1;
	logic          tl_s1;

	logic          accept;
	logic          byte_take;
	logic          fold_start;
	logic          fold_run;
	logic          clear_all;
	logic [CW-1:0] j_next;
	logic [TW-1:0] total;
	logic          over_cap;
	logic [EW-1:0] n_sel;

	logic [DW-1:0] fold_digit;
	logic [LW-1:0] low_t;
	logic [PW-1:0] prod;
	logic [QW-1:0] q_low;
	logic [LW-1:0] rem_w;
	logic [KW-1:0] q_next;

	assign accept     = (state_q == b58enc_pkg::ST_IDLE) && start;
	assign byte_take  = accept && (byte_q < BW'(MAX_BYTES));
	assign fold_start = byte_take && (seen_q || (item.data_byte != '0));
	assign j_next     = j_q + CW'(1);
	assign fold_run   = (state_q == b58enc_pkg::ST_FOLD) && (j_q < CW'(MAX_DIGITS))
		&& ((j_q < dcount_q) || (carry_q != '0));

	assign total    = TW'(zero_q) + TW'(dcount_q);
	assign over_cap = total > TW'(b58enc_pkg::RESULT_CAP);
	assign n_sel    = over_cap ? EW'(b58enc_pkg::RESULT_CAP) : total[EW-1:0];

	// one base-58 digit step: v = d*256 + carry, split as 4*d*58 + (24*d + carry)
	assign fold_digit = (j_q < dcount_q) ? rd_q : '0;
	assign low_t  = LW'(fold_digit) * LW'(b58enc_pkg::LOW_MUL) + LW'(carry_q);
	assign prod   = PW'(low_t) * PW'(b58enc_pkg::RECIP);
	assign q_low  = prod[PW-1:b58enc_pkg::RECIP_SH];
	assign rem_w  = low_t - LW'(q_low) * LW'(b58enc_pkg::RADIX);
	assign q_next = KW'({fold_digit, 2'b00}) + KW'(q_low);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b58enc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		clear_all = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		case (state_q)
			b58enc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					if (fold_start) begin
						state_d = b58enc_pkg::ST_FOLD;
						rd_en   = 1'b1;
					end else if (item.last_byte) begin
						state_d = b58enc_pkg::ST_PREP;
					end
				end
			end
			b58enc_pkg::ST_FOLD: begin
				if (fold_run) begin
					// prefetch the next digit while this one is written back
					if (j_next < CW'(MAX_DIGITS)) begin
						rd_en   = 1'b1;
						rd_addr = j_next[AW-1:0];
					end
				end else begin
					state_d = last_pend_q ? b58enc_pkg::ST_PREP : b58enc_pkg::ST_IDLE;
				end
			end
			b58enc_pkg::ST_PREP: begin
				if (n_sel == '0) begin
					state_d   = b58enc_pkg::ST_IDLE;
					clear_all = 1'b1;
				end else begin
					state_d = b58enc_pkg::ST_EMIT;
				end
			end
			b58enc_pkg::ST_EMIT: begin
				if (zeros_left_q == '0) begin
					rd_en   = 1'b1;
					rd_addr = pos_q;
				end
				if (emit_left_q == EW'(1)) begin
					state_d   = b58enc_pkg::ST_IDLE;
					clear_all = 1'b1;
				end
			end
			default: begin
				state_d = b58enc_pkg::ST_IDLE;
			end
		endcase
	end

	// digit store: entries at or above dcount_q are never read as data
	always_ff @(posedge clk) begin
		if (fold_run) begin
			mem[j_q[AW-1:0]] <= rem_w[DW-1:0];
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcount_q     <= '0;
			zero_q       <= '0;
			byte_q       <= '0;
			seen_q       <= 1'b0;
			ovf_q        <= 1'b0;
			last_pend_q  <= 1'b0;
			j_q          <= '0;
			carry_q      <= '0;
			emit_left_q  <= '0;
			zeros_left_q <= '0;
			pos_q        <= '0;
		end else begin
			if (accept) begin
				last_pend_q <= item.last_byte;
				j_q         <= '0;
				carry_q     <= item.data_byte;
				if (byte_take) begin
					byte_q <= byte_q + BW'(1);
					if (fold_start) begin
						seen_q <= 1'b1;
					end else begin
						zero_q <= zero_q + BW'(1);
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (fold_run) begin
				carry_q <= q_next;
				j_q     <= j_next;
				if (j_q >= dcount_q) begin
					dcount_q <= j_next;
				end
			end else if (state_q == b58enc_pkg::ST_FOLD && carry_q != '0) begin
				// carry left over with the store full
				ovf_q <= 1'b1;
			end
			if (state_q == b58enc_pkg::ST_PREP) begin
				emit_left_q  <= n_sel;
				zeros_left_q <= zero_q;
				pos_q        <= AW'(dcount_q - CW'(1));
				if (over_cap) begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == b58enc_pkg::ST_EMIT) begin
				emit_left_q <= emit_left_q - EW'(1);
				if (zeros_left_q != '0) begin
					zeros_left_q <= zeros_left_q - BW'(1);
				end else begin
					pos_q <= pos_q - AW'(1);
				end
			end
			if (clear_all) begin
				dcount_q <= '0;
				zero_q   <= '0;
				byte_q   <= '0;
				seen_q   <= 1'b0;
				ovf_q    <= 1'b0;
			end
		end
	end

	// output stage lines up with the registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == b58enc_pkg::ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		one_s1  <= (zeros_left_q != '0);
		last_s1 <= (emit_left_q == EW'(1));
		tl_s1   <= ovf_q;
	end

	assign strobe           = valid_s1;
	assign result.out_char  = one_s1 ? b58enc_pkg::CHAR_ONE : b58enc_pkg::alpha_char(rd_q);
	assign result.last_char = last_s1;
	assign result.too_long  = tl_s1;

endmodule

// ===== rtl/b58enc_checker.sv =====
module b58enc_prop_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                busy,
	input logic                strobe,
	input b58enc_pkg::result_t result
);

	// characters of one string come out without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_char |=> strobe)
		else $error("gap inside an encoded string");

	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_char |=> !strobe)
		else $error("character right after the final one");

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_char |-> busy)
		else $error("block idle while a string is still being sent");

	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) && !$past(result.last_char)
			|-> result.too_long == $past(result.too_long))
		else $error("too_long changed within a string");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.out_char >= 7'h31) && (result.out_char <= 7'h7a))
		else $error("character outside the alphabet");

endmodule

bind base58_encoder_top b58enc_prop_checker u_b58enc_prop_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
